// File: sv/cc20_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared constants, register indexes and controller/datapath command types
// for the ChaCha20 byte-stream cipher.
// ----------------------------------------------------------------------------
package cc20_pkg;

  // Block geometry
  localparam int NumWords        = 16;
  localparam int NumDoubleRounds = 10;
  localparam int BlockBytes      = 64;
  localparam int PosW            = $clog2(BlockBytes);
  localparam int WordIdxW        = $clog2(NumWords);

  // One half quarter-round per cycle; column and diagonal round each take two half steps
  localparam int HalfSteps = NumDoubleRounds * 4;
  localparam int StepW     = $clog2(HalfSteps);

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_A     = 3'd0,
    REG_KEY_B     = 3'd1,
    REG_KEY_C     = 3'd2,
    REG_KEY_D     = 3'd3,
    REG_NONCE_LO  = 3'd4,
    REG_NONCE_HI  = 3'd5,
    REG_INIT_CTR  = 3'd6
  } cc20_reg_e;

  // "expand 32-byte k"
  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  typedef logic [31:0] cc20_word_t;

  // Controller to datapath
  typedef struct packed {
    logic cfg_we;       // store configuration beat
    logic take_item;    // capture input beat into hold register
    logic load;         // load working state from input state
    logic round;        // apply one half quarter-round step to all lanes
    logic diag;         // diagonal round when set, column round otherwise
    logic second_half;  // rotations 8/7 when set, 16/12 otherwise
    logic finish;       // add input state, publish keystream, bump counter
    logic emit;         // write output register
    logic emit_direct;  // emit from input port instead of hold register
  } cc20_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic blk_valid;    // keystream block has unused bytes
  } cc20_status_t;

endpackage

// File: sv/cc20_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_ctrl
// Sequencer for the cipher: accepts byte beats, runs block generation on a
// shared half quarter-round unit when no keystream is left, and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module cc20_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic                 m_axis_tready,
  output logic                 m_axis_tvalid,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  cc20_pkg::cc20_status_t status_i,
  output cc20_pkg::cc20_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_ROUND = 5'b00100,
    S_FINAL = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e                      state_q, state_d;
  logic [cc20_pkg::StepW-1:0]  step_q, step_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_free;
  logic                        in_acc;

  // Output register is free when empty or drained this cycle
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.cfg_we = cfg_valid_i && cfg_ready_o;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.take_item = 1'b1;
          if (status_i.blk_valid) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_direct = 1'b1;
          end else begin
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        step_d     = '0;
        state_d    = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.round       = 1'b1;
        cmd_o.second_half = step_q[0];
        cmd_o.diag        = step_q[1];
        if (step_q == cc20_pkg::StepW'(cc20_pkg::HalfSteps - 1)) begin
          state_d = S_FINAL;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_FINAL: begin
        cmd_o.finish = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Set valid on emit, drop it when the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: sv/cc20_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_datapath
// Configuration registers, block counter, working state with four parallel
// half quarter-round lanes, keystream block, byte pointer and output register.
// ----------------------------------------------------------------------------
module cc20_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cc20_pkg::cc20_cmd_t             cmd_i,
  output cc20_pkg::cc20_status_t          status_o,
  input  logic [cc20_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [cc20_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic [7:0]                      in_data_i,
  input  logic                            in_last_i,
  output logic [7:0]                      out_data_o,
  output logic                            out_last_o
);

  typedef struct packed {
    cc20_pkg::cc20_word_t a;
    cc20_pkg::cc20_word_t b;
    cc20_pkg::cc20_word_t c;
    cc20_pkg::cc20_word_t d;
  } qr_t;

  // Word index of one quarter-round operand; diagonal rounds shift columns
  function automatic logic [cc20_pkg::WordIdxW-1:0] qr_index(
    input logic       diag,
    input logic [1:0] lane,
    input logic [1:0] role
  );
    logic [1:0] col;
    col = lane + (diag ? role : 2'd0);
    return {role, col};
  endfunction

  // Half of a quarter-round: two add, xor, rotate steps
  function automatic qr_t half_qr(input qr_t x, input logic second);
    qr_t        r;
    logic [31:0] t;
    r   = x;
    r.a = r.a + r.b;
    t   = r.d ^ r.a;
    r.d = second ? {t[23:0], t[31:24]} : {t[15:0], t[31:16]};
    r.c = r.c + r.d;
    t   = r.b ^ r.c;
    r.b = second ? {t[24:0], t[31:25]} : {t[19:0], t[31:20]};
    return r;
  endfunction

  logic [63:0]                   key_q [4];
  logic [63:0]                   nonce_lo_q;
  logic [31:0]                   nonce_hi_q;
  logic [31:0]                   init_ctr_q;
  logic [31:0]                   block_ctr_q;
  logic [31:0]                   reload_ctr;
  logic                          blk_valid_q;
  logic [cc20_pkg::PosW-1:0]     pos_q;

  cc20_pkg::cc20_word_t          in_state [cc20_pkg::NumWords];
  cc20_pkg::cc20_word_t          work_q   [cc20_pkg::NumWords];
  cc20_pkg::cc20_word_t          work_rnd [cc20_pkg::NumWords];
  cc20_pkg::cc20_word_t          ks_q     [cc20_pkg::NumWords];

  logic [7:0]                    hold_data_q;
  logic                          hold_last_q;
  logic [7:0]                    out_data_q;
  logic                          out_last_q;
  logic [7:0]                    src_data;
  logic                          src_last;
  cc20_pkg::cc20_word_t          ks_word;
  logic [7:0]                    ks_byte;

  // Assemble input state from constants, key, counter and nonce
  always_comb begin
    in_state[0]  = cc20_pkg::Sigma0;
    in_state[1]  = cc20_pkg::Sigma1;
    in_state[2]  = cc20_pkg::Sigma2;
    in_state[3]  = cc20_pkg::Sigma3;
    for (int k = 0; k < 4; k++) begin
      in_state[4 + 2*k] = key_q[k][31:0];
      in_state[5 + 2*k] = key_q[k][63:32];
    end
    in_state[12] = block_ctr_q;
    in_state[13] = nonce_lo_q[31:0];
    in_state[14] = nonce_lo_q[63:32];
    in_state[15] = nonce_hi_q;
  end

  // Four independent lanes of the half quarter-round step
  always_comb begin
    qr_t                           x;
    qr_t                           r;
    logic [cc20_pkg::WordIdxW-1:0] ia, ib, ic, id;
    work_rnd = work_q;
    for (int lane = 0; lane < 4; lane++) begin
      ia  = qr_index(cmd_i.diag, 2'(lane), 2'd0);
      ib  = qr_index(cmd_i.diag, 2'(lane), 2'd1);
      ic  = qr_index(cmd_i.diag, 2'(lane), 2'd2);
      id  = qr_index(cmd_i.diag, 2'(lane), 2'd3);
      x.a = work_q[ia];
      x.b = work_q[ib];
      x.c = work_q[ic];
      x.d = work_q[id];
      r   = half_qr(x, cmd_i.second_half);
      work_rnd[ia] = r.a;
      work_rnd[ib] = r.b;
      work_rnd[ic] = r.c;
      work_rnd[id] = r.d;
    end
  end

  // Working state and keystream block
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      work_q <= in_state;
    end else if (cmd_i.round) begin
      work_q <= work_rnd;
    end
    if (cmd_i.finish) begin
      for (int i = 0; i < cc20_pkg::NumWords; i++) begin
        ks_q[i] <= work_q[i] + in_state[i];
      end
    end
  end

  // Counter reload takes the freshly written value on an initial counter write
  assign reload_ctr = (cfg_index_i == cc20_pkg::REG_INIT_CTR) ? cfg_data_i[31:0]
                                                             : init_ctr_q;

  // Source byte for the output beat
  assign src_data = cmd_i.emit_direct ? in_data_i : hold_data_q;
  assign src_last = cmd_i.emit_direct ? in_last_i : hold_last_q;

  // Select keystream byte, little-endian within each word
  assign ks_word = ks_q[pos_q[cc20_pkg::PosW-1:2]];
  assign ks_byte = ks_word[{pos_q[1:0], 3'b000} +: 8];

  // Configuration, counter and byte pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        key_q[k] <= '0;
      end
      nonce_lo_q  <= '0;
      nonce_hi_q  <= '0;
      init_ctr_q  <= '0;
      block_ctr_q <= '0;
      blk_valid_q <= 1'b0;
      pos_q       <= '0;
    end else if (cmd_i.cfg_we) begin
      unique case (cfg_index_i)
        cc20_pkg::REG_KEY_A:    key_q[0]   <= cfg_data_i;
        cc20_pkg::REG_KEY_B:    key_q[1]   <= cfg_data_i;
        cc20_pkg::REG_KEY_C:    key_q[2]   <= cfg_data_i;
        cc20_pkg::REG_KEY_D:    key_q[3]   <= cfg_data_i;
        cc20_pkg::REG_NONCE_LO: nonce_lo_q <= cfg_data_i;
        cc20_pkg::REG_NONCE_HI: nonce_hi_q <= cfg_data_i[31:0];
        cc20_pkg::REG_INIT_CTR: init_ctr_q <= cfg_data_i[31:0];
        default: ;
      endcase
      // Any index within the list reloads the counter and drops the block
      if (cfg_index_i <= cc20_pkg::REG_INIT_CTR) begin
        block_ctr_q <= reload_ctr;
        blk_valid_q <= 1'b0;
      end
    end else if (cmd_i.finish) begin
      block_ctr_q <= block_ctr_q + 32'd1;
      blk_valid_q <= 1'b1;
      pos_q       <= '0;
    end else if (cmd_i.emit) begin
      pos_q <= pos_q + 1'b1;
      if (src_last || (pos_q == cc20_pkg::PosW'(cc20_pkg::BlockBytes - 1))) begin
        blk_valid_q <= 1'b0;
      end
    end
  end

  // Hold and output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      hold_data_q <= in_data_i;
      hold_last_q <= in_last_i;
    end
    if (cmd_i.emit) begin
      out_data_q <= src_data ^ ks_byte;
      out_last_q <= src_last;
    end
  end

  assign status_o.blk_valid = blk_valid_q;
  assign out_data_o         = out_data_q;
  assign out_last_o         = out_last_q;

endmodule

// File: sv/chacha20_stream_cipher_top.sv
`timescale 1ns / 1ps
// A byte with keystream left reaches the output register in the cycle after its beat.
// A byte that needs a new block waits for the load, 40 half quarter-round steps
// on the shared four-lane round unit, the final add and the output write; input waits.
// Within a 64-byte block, 1 byte per cycle unless output or config write stalls input.
// Reset: key, nonce and initial counter clear to zero, counter 0, no block held.
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_top
// ChaCha20 byte-stream cipher: XORs each data byte with the next keystream
// byte; tlast ends a message and drops the rest of the current block.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] data_in
  input  logic                          s_axis_tlast,   // last_of_call
  // Output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // [7:0] data_out
  output logic                          m_axis_tlast,   // last_out
  // Configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cc20_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cc20_pkg::CfgDataW-1:0] cfg_data_i
);

  cc20_pkg::cc20_cmd_t    cmd;
  cc20_pkg::cc20_status_t status;

  cc20_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  cc20_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// File: sv/cc20_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_checker
// Port-level checks on the cipher: output beat stability, no input beat
// into a stalled output, config and data beats never coincide, and every
// input beat either shows a result or stalls the input next cycle.
// ----------------------------------------------------------------------------
module cc20_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [7:0]                    m_axis_tdata,
  input logic                          m_axis_tlast,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o
);

  logic in_acc;
  logic cfg_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // Input is never taken while a result waits unclaimed
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("input beat accepted over a pending result");

  // Configuration and data beats never complete together
  a_cfg_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && cfg_acc))
    else $error("config and data beat in the same cycle");

  // An accepted byte shows a result at once or blocks further input
  a_in_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (m_axis_tvalid || !s_axis_tready))
    else $error("input beat lost");

endmodule

bind chacha20_stream_cipher_top cc20_checker u_cc20_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o)
);
